[rtl/rfex_pkg.sv]
// rfex_pkg: shared constants for the register file execute unit
// operation codes, register file geometry and pc region split
// no dependencies
package rfex_pkg;

   localparam int REG_COUNT       = 32;
   localparam int REG_AW          = $clog2(REG_COUNT);
   localparam int DATA_W          = 32;
   localparam int PC_REGION_SHIFT = 28;

   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_OR   = 4'd2;
   localparam logic [3:0] OP_BINS = 4'd3;
   localparam logic [3:0] OP_CLZ  = 4'd4;
   localparam logic [3:0] OP_SLTI = 4'd5;
   localparam logic [3:0] OP_SSAT = 4'd6;
   localparam logic [3:0] OP_USAT = 4'd7;
   localparam logic [3:0] OP_BEQ  = 4'd8;
   localparam logic [3:0] OP_JUMP = 4'd9;

   typedef logic [REG_AW-1:0] reg_idx_type;
   typedef logic [DATA_W-1:0] data_type;

endpackage

[rtl/register_file_alu_execute_top.sv]
// register_file_alu_execute_top: integer execute unit with register file and pc
// depends on rfex_pkg
//
// usage:
//   req_* carries one decoded instruction per transfer (req_valid high, req_stall low).
//   rsp_* carries one result per instruction, in order, under the same handshake.
//   the register file is read at the transfer edge (synchronous memory) into
//   the execute stage, which executes, writes back and updates the pc as the
//   result is registered.
//   throughput: one instruction per cycle, back to back, while rsp_stall is low;
//   a write made in the execute cycle is forwarded to the instruction read in
//   that same cycle.
//   two copies of the register file give the three read ports (rs, rt, rd).
//   reset (synchronous, active high) empties the pipeline, sets the pc to zero
//   and clears a valid bit per register, so every register reads as zero until
//   written; no clearing pass is needed.
//   when rsp_stall is high the result register holds its contents; the execute
//   stage still fills behind it, and req_stall rises only once both are full.
module register_file_alu_execute_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_mode,
   input  logic [4:0]          req_dest_reg,
   input  logic [4:0]          req_src_a_reg,
   input  logic [4:0]          req_src_b_reg,
   input  logic signed [15:0]  req_immediate,
   input  logic [25:0]         req_jump_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_reg_written,
   output logic [4:0]          rsp_written_reg,
   output logic signed [31:0]  rsp_written_value,
   output logic                rsp_branch_taken,
   output logic [31:0]         rsp_program_counter
);
   import rfex_pkg::*;

   // register file copies and per-register valid bits
   data_type     rf_main [REG_COUNT];
   data_type     rf_dest [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff, valid_in;

   // execute stage
   logic         s1_valid_ff, s1_valid_in;
   logic [3:0]   s1_mode_ff;
   reg_idx_type  s1_rd_ff, s1_rs_ff, s1_rt_ff;
   logic [15:0]  s1_imm_ff;
   logic [25:0]  s1_jidx_ff;
   data_type     rd_a_ff, rd_b_ff, rd_d_ff;
   logic         va_ff, vb_ff, vd_ff;

   // write performed on the edge that loaded the execute stage
   logic         fwd_en_ff;
   reg_idx_type  fwd_addr_ff;
   data_type     fwd_data_ff;

   logic [31:0]  pc_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_wr_ff, rsp_taken_ff;
   logic [4:0]   rsp_reg_ff;
   data_type     rsp_val_ff;

   logic         req_fire, s1_adv;
   data_type     op_a, op_b, op_d;
   logic         wr_en, taken;
   reg_idx_type  wreg;
   data_type     val;
   logic [31:0]  pc_next;
   logic [5:0]   clz_cnt;
   data_type     imm_ext;
   logic         ssat_on, usat_on;
   data_type     ssat_hi, ssat_lo, usat_hi;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   // operand select: forwarded write, else memory, else reset value
   assign op_a = (fwd_en_ff && fwd_addr_ff == s1_rs_ff) ? fwd_data_ff
               : (va_ff ? rd_a_ff : '0);
   assign op_b = (fwd_en_ff && fwd_addr_ff == s1_rt_ff) ? fwd_data_ff
               : (vb_ff ? rd_b_ff : '0);
   assign op_d = (fwd_en_ff && fwd_addr_ff == s1_rd_ff) ? fwd_data_ff
               : (vd_ff ? rd_d_ff : '0);

   assign imm_ext = {{(DATA_W-16){s1_imm_ff[15]}}, s1_imm_ff};

   // leading zero count as a priority encoder
   always_comb begin
      clz_cnt = 6'(DATA_W);
      for (int i = 0; i < DATA_W; i++) begin
         if (op_a[i]) clz_cnt = 6'(DATA_W - 1 - i);
      end
   end

   // saturate bounds
   assign ssat_on = !s1_imm_ff[15] && (s1_imm_ff[14:5] == '0) && (s1_imm_ff[4:0] != '0);
   assign ssat_hi = (data_type'(1) << (s1_imm_ff[4:0] - 5'd1)) - data_type'(1);
   assign ssat_lo = ~ssat_hi;
   assign usat_on = s1_imm_ff[7:0] < 8'd31;
   assign usat_hi = (data_type'(1) << s1_imm_ff[4:0]) - data_type'(1);

   always_comb begin
      wr_en   = 1'b0;
      taken   = 1'b0;
      wreg    = '0;
      val     = '0;
      pc_next = pc_ff;
      unique case (s1_mode_ff)
         OP_ADD: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = op_a + op_b;
         end
         OP_SUB: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = op_a - op_b;
         end
         OP_OR: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = op_a | op_b;
         end
         OP_BINS: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = (op_d & ~op_b) | (op_a & op_b);
         end
         OP_CLZ: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = data_type'(clz_cnt);
         end
         OP_SLTI: begin
            wr_en = 1'b1; wreg = s1_rt_ff;
            val = data_type'($signed(op_a) < $signed(imm_ext));
         end
         OP_SSAT: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = op_a;
            if (ssat_on) begin
               if ($signed(op_a) > $signed(ssat_hi)) val = ssat_hi;
               else if ($signed(op_a) < $signed(ssat_lo)) val = ssat_lo;
            end
         end
         OP_USAT: begin
            wr_en = 1'b1; wreg = s1_rd_ff; val = op_a;
            if (usat_on && $signed(op_a) > $signed(usat_hi)) val = usat_hi;
         end
         OP_BEQ: begin
            if (op_a == op_b) begin
               taken   = 1'b1;
               pc_next = pc_ff + {imm_ext[DATA_W-3:0], 2'b00};
            end
         end
         OP_JUMP: begin
            taken   = 1'b1;
            pc_next = {pc_ff[31:PC_REGION_SHIFT], s1_jidx_ff, 2'b00};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (s1_adv && wr_en) valid_in[wreg] = 1'b1;
   end

   // register file: write back on retire, read on request transfer
   always_ff @(posedge clock) begin
      if (s1_adv && wr_en) begin
         rf_main[wreg] <= val;
         rf_dest[wreg] <= val;
      end
      if (req_fire) begin
         rd_a_ff <= rf_main[req_src_a_reg[REG_AW-1:0]];
         rd_b_ff <= rf_main[req_src_b_reg[REG_AW-1:0]];
         rd_d_ff <= rf_dest[req_dest_reg[REG_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_mode;
         s1_rd_ff    <= req_dest_reg[REG_AW-1:0];
         s1_rs_ff    <= req_src_a_reg[REG_AW-1:0];
         s1_rt_ff    <= req_src_b_reg[REG_AW-1:0];
         s1_imm_ff   <= req_immediate;
         s1_jidx_ff  <= req_jump_index;
         va_ff       <= valid_in[req_src_a_reg[REG_AW-1:0]];
         vb_ff       <= valid_in[req_src_b_reg[REG_AW-1:0]];
         vd_ff       <= valid_in[req_dest_reg[REG_AW-1:0]];
         fwd_addr_ff <= wreg;
         fwd_data_ff <= val;
      end
      if (s1_adv) begin
         rsp_wr_ff    <= wr_en;
         rsp_reg_ff   <= 5'(wreg);
         rsp_val_ff   <= val;
         rsp_taken_ff <= taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_en_ff    <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) fwd_en_ff <= s1_adv && wr_en;
         if (s1_adv) pc_ff <= pc_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reg_written     = rsp_wr_ff;
   assign rsp_written_reg     = rsp_reg_ff;
   assign rsp_written_value   = rsp_val_ff;
   assign rsp_branch_taken    = rsp_taken_ff;
   assign rsp_program_counter = pc_ff;

endmodule

[rtl/rfex_checker.sv]
// rfex_checker: port-level assertions for the execute unit, bound to the top level
// depends on register_file_alu_execute_top port names
module rfex_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_reg_written,
   input logic [4:0]         rsp_written_reg,
   input logic signed [31:0] rsp_written_value,
   input logic               rsp_branch_taken,
   input logic [31:0]        rsp_program_counter
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // an instruction never both writes a register and redirects the pc
   a_write_xor_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_written |-> !rsp_branch_taken)
      else $error("register write and branch in one result");

   // results without a write report zero index and value
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_written_reg == '0 && rsp_written_value == '0)
      else $error("non-writing result carries register data");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_written_value)
         && $stable(rsp_program_counter) && $stable(rsp_reg_written))
      else $error("stalled result changed");

endmodule

bind register_file_alu_execute_top rfex_checker u_rfex_checker (.*);
